@@ rtl/core/earliest_free_worker_scheduler_macros.svh @@
// Assertion macros for the earliest-free worker scheduler checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_MACROS_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_MACROS_SVH

// same-cycle implication
`define EWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ews_pkg.sv @@
// Shared types and constants for the earliest-free worker scheduler.
// No dependencies; imported by every module of the block.
package ews_pkg;

  localparam int unsigned DUR_W           = 32;
  localparam int unsigned TIME_W          = 64;
  localparam int unsigned WID_W           = 4;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned MAX_WORKERS_DEF = 16;
  localparam int unsigned IN_TDATA_W      = 32;
  localparam int unsigned OUT_TDATA_W     = 72;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // register index as seen on paddr[2]
  localparam logic REG_WORKER_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_ROOT_RD,
    ST_ROOT_WAIT,
    ST_SIFT_RD,
    ST_SIFT_CMP
  } ews_state_e;

  typedef struct packed {
    logic             valid;
    logic [DUR_W-1:0] dur;
  } ews_job_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } ews_back_stat_t;

endpackage

@@ rtl/core/ews_front.sv @@
// Front end: accepts job durations and holds them in a short queue.
// Depends on ews_pkg; feeds ews_back.
module ews_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ews_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [31:0] job_duration
  input  ews_pkg::ews_back_stat_t      back_stat_i,
  output ews_pkg::ews_job_t            job_o
);
  import ews_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DUR_W-1:0]  buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign s_axis_tready = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && !back_stat_i.busy;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = back_stat_i.pop;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= s_axis_tdata[DUR_W-1:0];
    end
  end

  assign job_o.valid = (cnt_q != '0);
  assign job_o.dur   = buf_q[rd_ptr_q];

endmodule

@@ rtl/core/ews_back.sv @@
// Back end: heap memory, replace-root sift-down sequencer and output register.
// Depends on ews_pkg; takes jobs from ews_front.
module ews_back #(
  parameter int unsigned MAX_WORKERS = ews_pkg::MAX_WORKERS_DEF,
  localparam int unsigned NW = $clog2(MAX_WORKERS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [NW-1:0]                 n_i,
  input  logic                          restart_i,
  input  ews_pkg::ews_job_t             job_i,
  output ews_pkg::ews_back_stat_t       stat_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ews_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // [3:0] worker_id, [67:4] start_time
);
  import ews_pkg::*;

  localparam int unsigned IW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned XW  = IW + 1;
  localparam int unsigned PAD = OUT_TDATA_W - WID_W - TIME_W;

  logic [TIME_W-1:0] mem_time [MAX_WORKERS];
  logic [IW-1:0]     mem_wid  [MAX_WORKERS];

  ews_state_e        state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [TIME_W-1:0] cur_time_q, cur_time_d;
  logic [IW-1:0]     cur_wid_q, cur_wid_d;
  logic              rok_q, rok_d;
  logic [TIME_W-1:0] rd_a_time_q, rd_b_time_q;
  logic [IW-1:0]     rd_a_wid_q, rd_b_wid_q;
  logic              out_vld_q, out_vld_d;
  logic [WID_W-1:0]  out_wid_q;
  logic [TIME_W-1:0] out_time_q;

  logic              we, re;
  logic [IW-1:0]     waddr, ra, rb;
  logic [TIME_W-1:0] wtime;
  logic [IW-1:0]     wwid;
  logic              out_free, out_load;
  logic [XW-1:0]     lidx, ridx;
  logic              pick_r, c_less;
  logic [TIME_W-1:0] c_time;
  logic [IW-1:0]     c_wid, c_idx;
  logic [IW+WID_W-1:0] wid_ext;

  assign out_free = !out_vld_q || m_axis_tready;
  assign lidx     = {idx_q, 1'b1};
  assign ridx     = lidx + XW'(1);
  assign wid_ext  = {{WID_W{1'b0}}, rd_a_wid_q};

  always_comb begin
    pick_r = rok_q && ((rd_b_time_q < rd_a_time_q) ||
                       ((rd_b_time_q == rd_a_time_q) && (rd_b_wid_q < rd_a_wid_q)));
    c_time = pick_r ? rd_b_time_q : rd_a_time_q;
    c_wid  = pick_r ? rd_b_wid_q : rd_a_wid_q;
    c_idx  = pick_r ? ridx[IW-1:0] : lidx[IW-1:0];
    c_less = (c_time < cur_time_q) || ((c_time == cur_time_q) && (c_wid < cur_wid_q));
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cur_time_d = cur_time_q;
    cur_wid_d  = cur_wid_q;
    rok_d      = rok_q;
    we         = 1'b0;
    waddr      = idx_q;
    wtime      = cur_time_q;
    wwid       = cur_wid_q;
    re         = 1'b0;
    ra         = '0;
    rb         = '0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wtime = '0;
        wwid  = idx_q;
        if ((XW'(idx_q) + XW'(1)) == XW'(n_i)) begin
          idx_d   = '0;
          state_d = ST_ROOT_RD;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_ROOT_RD: begin
        if (job_i.valid) begin
          re      = 1'b1;
          state_d = ST_ROOT_WAIT;
        end
      end
      ST_ROOT_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          cur_time_d = rd_a_time_q + TIME_W'(job_i.dur);
          cur_wid_d  = rd_a_wid_q;
          idx_d      = '0;
          state_d    = ST_SIFT_RD;
        end
      end
      ST_SIFT_RD: begin
        if (lidx >= XW'(n_i)) begin
          we      = 1'b1;
          state_d = ST_ROOT_RD;
        end else begin
          re      = 1'b1;
          ra      = lidx[IW-1:0];
          rok_d   = ridx < XW'(n_i);
          rb      = (ridx < XW'(n_i)) ? ridx[IW-1:0] : lidx[IW-1:0];
          state_d = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: begin
        we = 1'b1;
        if (c_less) begin
          wtime   = c_time;
          wwid    = c_wid;
          idx_d   = c_idx;
          state_d = ST_SIFT_RD;
        end else begin
          state_d = ST_ROOT_RD;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        idx_d   = '0;
      end
    endcase
    if (restart_i) begin
      state_d = ST_CLEAR;
      idx_d   = '0;
    end
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_time_q <= cur_time_d;
    cur_wid_q  <= cur_wid_d;
    rok_q      <= rok_d;
    if (out_load) begin
      out_wid_q  <= wid_ext[WID_W-1:0];
      out_time_q <= rd_a_time_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_time[waddr] <= wtime;
      mem_wid[waddr]  <= wwid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_a_time_q <= mem_time[ra];
      rd_a_wid_q  <= mem_wid[ra];
      rd_b_time_q <= mem_time[rb];
      rd_b_wid_q  <= mem_wid[rb];
    end
  end

  assign stat_o.pop    = out_load;
  assign stat_o.busy   = (state_q == ST_CLEAR);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD{1'b0}}, out_time_q, out_wid_q};

endmodule

@@ rtl/core/earliest_free_worker_scheduler.sv @@
// Channel   | Dir | Handshake            | Payload
// job in    | in  | s_axis_tvalid/tready | tdata[31:0] job_duration
// result    | out | m_axis_tvalid/tready | tdata[3:0] worker_id, [67:4] start_time
// config    | in  | APB psel/penable     | reg 0 worker_count at byte address 0
//
// A job passes the root read and root wait states, then for each heap level
// it descends among the N workers one read and one compare state, set by the
// heap memory's two read ports. After reset and after each worker_count write,
// a clearing pass rewrites the heap; no job is accepted meanwhile. A two-entry
// queue and the output register let the input and the result side stall on their own.
module earliest_free_worker_scheduler #(
  parameter int unsigned MAX_WORKERS = ews_pkg::MAX_WORKERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ews_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] job_duration
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ews_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [3:0] worker_id, [67:4] start_time
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ews_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ews_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ews_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ews_pkg::*;

  localparam int unsigned NW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CW = (NW > CNT_W) ? NW : CNT_W;

  logic [NW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  wr_val;
  logic           cfg_wr;
  ews_job_t       job;
  ews_back_stat_t back_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WORKER_COUNT);
  assign prdata = (paddr[2] == REG_WORKER_COUNT) ? APB_DATA_W'(cnt_q) : '0;

  always_comb begin
    wr_val = CW'(pwdata[CNT_W-1:0]);
    if (wr_val == '0) begin
      wr_val = CW'(1);
    end else if (wr_val > CW'(MAX_WORKERS)) begin
      wr_val = CW'(MAX_WORKERS);
    end
    cnt_d = cfg_wr ? NW'(wr_val) : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= NW'(1);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  ews_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .back_stat_i   (back_stat),
    .job_o         (job)
  );

  ews_back #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (cnt_q),
    .restart_i     (cfg_wr),
    .job_i         (job),
    .stat_o        (back_stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ rtl/core/ews_checker.sv @@
// Port-level checker for the earliest-free worker scheduler, bound to the top.
// Depends on ews_pkg and earliest_free_worker_scheduler_macros.svh.
`include "earliest_free_worker_scheduler_macros.svh"

module ews_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ews_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [ews_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [ews_pkg::APB_DATA_W-1:0]  prdata,
  input logic                            pready
);
  import ews_pkg::*;

  `EWS_ASSERT_NXT(a_out_hold, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata)), "result dropped or changed while stalled")
  `EWS_ASSERT_NXT(a_clear_blocks, (psel && penable && pwrite && pready && (paddr[2] == REG_WORKER_COUNT)), (!s_axis_tready), "job accepted during heap clearing")
  `EWS_ASSERT_IMP(a_pad_zero, m_axis_tvalid, (m_axis_tdata[OUT_TDATA_W-1:WID_W+TIME_W] == '0), "result padding not zero")
  `EWS_ASSERT_IMP(a_count_nonzero, (psel && !pwrite && (paddr[2] == REG_WORKER_COUNT)), (prdata != '0), "worker count reads as zero")

endmodule

bind earliest_free_worker_scheduler ews_checker u_ews_checker (.*);
